>>> rtl/core/lzd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZ77 decompressor package
// Shared constants and types for the LZ10-style byte stream decoder.
// ----------------------------------------------------------------------------
package lzd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_BITS     = $clog2(WINDOW_DEPTH);
    localparam int LENGTH_BITS  = 24;
    localparam int COPY_BITS    = 5;
    localparam int LEN_BIAS     = 3;
    localparam int DIST_BIAS    = 1;
    localparam int FLAG_COUNT   = 8;
    localparam int PADDR_BITS   = 3;

    localparam logic REG_PACK_HALFWORDS = 1'b0;

    typedef logic [WIN_BITS-1:0] t_addr;

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LEN,
        PH_FLAG,
        PH_ELEM,
        PH_PAIR2
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PUT
    } t_state;

endpackage
`default_nettype wire

>>> rtl/core/lz77_byte_stream_decompressor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZ77 byte stream decompressor core
// Parses header, flag, literal and pair bytes and copies from a 4 KiB
// history memory; emits bytes or little-endian halfwords.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_data_byte
//  output    out        o_out_valid / i_out_stall o_out_data, o_out_bytes,
//                                                 o_item_done, o_stream_done
//  config    in         psel/penable/pready       paddr, pwdata, prdata
//
//  Header, flag and first pair bytes are taken in ST_IDLE; a literal also passes through ST_PUT.
//  A copy does one history read (ST_READ) and one write-back (ST_PUT) per byte
//  through the single-port-read history memory.
//  Reset needs no clearing pass: a fill count makes never-written history
//  read as zero. Output stall only holds the block when a result is due.
// ----------------------------------------------------------------------------
module lz77_byte_stream_decompressor_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [7:0]                    i_data_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [15:0]                        o_out_data,
    output logic [1:0]                         o_out_bytes,
    output logic                               o_item_done,
    output logic                               o_stream_done,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lzd_pkg::PADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import lzd_pkg::*;

    t_state                  r_state, n_state;
    t_phase                  r_phase, n_phase;
    logic [1:0]              r_hdr_idx, n_hdr_idx;
    logic [LENGTH_BITS-1:0]  r_rem, n_rem;
    logic [7:0]              r_flag_bits, n_flag_bits;
    logic [3:0]              r_flag_cnt, n_flag_cnt;
    logic [7:0]              r_pair_high, n_pair_high;
    logic [7:0]              r_pend_byte, n_pend_byte;
    logic                    r_pend_valid, n_pend_valid;
    logic                    r_pack, n_pack;
    t_addr                   r_wp, n_wp;
    logic [WIN_BITS:0]       r_fill, n_fill;
    logic [7:0]              r_byte, n_byte;
    logic                    r_from_mem, n_from_mem;
    logic [COPY_BITS-1:0]    r_copy_left, n_copy_left;
    t_addr                   r_dist, n_dist;
    logic                    r_rd_zero, n_rd_zero;
    logic [7:0]              r_rd_data;
    logic                    r_out_valid, n_out_valid;
    logic [15:0]             r_out_data, n_out_data;
    logic [1:0]              r_out_bytes, n_out_bytes;
    logic                    r_item_done, n_item_done;
    logic                    r_stream_done, n_stream_done;

    logic [7:0]              mem [WINDOW_DEPTH];

    logic                    acc_in;
    logic                    cfg_wr;
    logic [7:0]              put_byte;
    logic                    need_out;
    logic                    slot_free;
    logic                    do_put;
    logic                    mem_re;
    t_addr                   rd_addr;
    logic [LENGTH_BITS-1:0]  rem_dec;
    logic [COPY_BITS-1:0]    copy_after;
    logic                    ends;
    logic [COPY_BITS-1:0]    eff;
    logic                    last_res;
    logic                    stream_end;
    logic [31:0]             len_shift;
    logic [LENGTH_BITS-1:0]  rem_or;
    logic [3:0]              cnt_dec;

    assign pready        = 1'b1;
    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_data    = r_out_data;
    assign o_out_bytes   = r_out_bytes;
    assign o_item_done   = r_item_done;
    assign o_stream_done = r_stream_done;
    assign prdata        = (paddr[PADDR_BITS-1] == REG_PACK_HALFWORDS) ?
                           {31'b0, r_pack} : 32'b0;

    always_comb begin
        acc_in     = i_in_valid && (r_state == ST_IDLE);
        cfg_wr     = psel && penable && pwrite && pready &&
                     (paddr[PADDR_BITS-1] == REG_PACK_HALFWORDS);
        put_byte   = r_from_mem ? (r_rd_zero ? 8'h00 : r_rd_data) : r_byte;
        need_out   = !r_pack || r_pend_valid;
        slot_free  = !r_out_valid || !i_out_stall;
        do_put     = (r_state == ST_PUT) && (!need_out || slot_free);
        mem_re     = (r_state == ST_READ);
        rd_addr    = r_wp - r_dist;
        rem_dec    = r_rem - LENGTH_BITS'(1);
        copy_after = r_copy_left - COPY_BITS'(1);
        ends       = rem_dec <= LENGTH_BITS'(copy_after);
        eff        = ends ? rem_dec[COPY_BITS-1:0] : copy_after;
        last_res   = r_pack ? (eff < COPY_BITS'(2)) : (eff == '0);
        stream_end = (rem_dec == '0);
        len_shift  = 32'(i_data_byte) << {r_hdr_idx, 3'b000};
        rem_or     = r_rem | len_shift[LENGTH_BITS-1:0];
        cnt_dec    = r_flag_cnt - 4'd1;

        n_state       = r_state;
        n_phase       = r_phase;
        n_hdr_idx     = r_hdr_idx;
        n_rem         = r_rem;
        n_flag_bits   = r_flag_bits;
        n_flag_cnt    = r_flag_cnt;
        n_pair_high   = r_pair_high;
        n_pend_byte   = r_pend_byte;
        n_pend_valid  = r_pend_valid;
        n_pack        = r_pack;
        n_wp          = r_wp;
        n_fill        = r_fill;
        n_byte        = r_byte;
        n_from_mem    = r_from_mem;
        n_copy_left   = r_copy_left;
        n_dist        = r_dist;
        n_rd_zero     = r_rd_zero;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;
        n_out_bytes   = r_out_bytes;
        n_item_done   = r_item_done;
        n_stream_done = r_stream_done;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (acc_in) begin
                    unique case (r_phase)
                        PH_LEN: begin
                            n_rem = rem_or;
                            if (r_hdr_idx >= 2'd2) begin
                                n_hdr_idx = 2'd0;
                                if (rem_or == '0) begin
                                    n_phase      = PH_TYPE;
                                    n_pend_valid = 1'b0;
                                end else begin
                                    n_phase = PH_FLAG;
                                end
                            end else begin
                                n_hdr_idx = r_hdr_idx + 2'd1;
                            end
                        end
                        PH_FLAG: begin
                            n_flag_bits = i_data_byte;
                            n_flag_cnt  = 4'(FLAG_COUNT);
                            n_phase     = PH_ELEM;
                        end
                        PH_ELEM: begin
                            if (r_flag_bits[7]) begin
                                n_pair_high = i_data_byte;
                                n_phase     = PH_PAIR2;
                            end else begin
                                n_byte      = i_data_byte;
                                n_from_mem  = 1'b0;
                                n_copy_left = COPY_BITS'(1);
                                n_state     = ST_PUT;
                            end
                        end
                        PH_PAIR2: begin
                            n_copy_left = COPY_BITS'(r_pair_high[7:4]) +
                                          COPY_BITS'(LEN_BIAS);
                            n_dist      = {r_pair_high[3:0], i_data_byte} +
                                          WIN_BITS'(DIST_BIAS);
                            n_from_mem  = 1'b1;
                            n_state     = ST_READ;
                        end
                        default: begin
                            n_rem        = '0;
                            n_hdr_idx    = 2'd0;
                            n_flag_cnt   = 4'd0;
                            n_flag_bits  = 8'd0;
                            n_pend_valid = 1'b0;
                            n_phase      = PH_LEN;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_rd_zero = !r_fill[WIN_BITS] && (rd_addr >= r_fill[WIN_BITS-1:0]);
                n_state   = ST_PUT;
            end
            ST_PUT: begin
                if (do_put) begin
                    n_wp  = r_wp + WIN_BITS'(1);
                    n_rem = rem_dec;
                    if (!r_fill[WIN_BITS]) begin
                        n_fill = r_fill + (WIN_BITS+1)'(1);
                    end
                    if (need_out) begin
                        n_out_valid   = 1'b1;
                        n_out_data    = r_pack ? {put_byte, r_pend_byte} :
                                                 {8'h00, put_byte};
                        n_out_bytes   = r_pack ? 2'd2 : 2'd1;
                        n_item_done   = last_res;
                        n_stream_done = last_res && ends;
                    end
                    if (r_pack) begin
                        if (r_pend_valid) begin
                            n_pend_valid = 1'b0;
                        end else begin
                            n_pend_byte  = put_byte;
                            n_pend_valid = 1'b1;
                        end
                    end
                    if (stream_end) begin
                        n_pend_valid = 1'b0;
                        n_phase      = PH_TYPE;
                        n_hdr_idx    = 2'd0;
                        n_flag_cnt   = 4'd0;
                        n_state      = ST_IDLE;
                    end else if (copy_after != '0) begin
                        n_copy_left = copy_after;
                        n_state     = ST_READ;
                    end else begin
                        n_flag_bits = {r_flag_bits[6:0], 1'b0};
                        n_flag_cnt  = cnt_dec;
                        n_phase     = (cnt_dec == 4'd0) ? PH_FLAG : PH_ELEM;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (cfg_wr) begin
            n_pack       = pwdata[0];
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase       <= PH_TYPE;
            r_hdr_idx     <= 2'd0;
            r_rem         <= '0;
            r_flag_bits   <= 8'd0;
            r_flag_cnt    <= 4'd0;
            r_pair_high   <= 8'd0;
            r_pend_valid  <= 1'b0;
            r_pack        <= 1'b0;
            r_wp          <= '0;
            r_fill        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_phase       <= n_phase;
            r_hdr_idx     <= n_hdr_idx;
            r_rem         <= n_rem;
            r_flag_bits   <= n_flag_bits;
            r_flag_cnt    <= n_flag_cnt;
            r_pair_high   <= n_pair_high;
            r_pend_valid  <= n_pend_valid;
            r_pack        <= n_pack;
            r_wp          <= n_wp;
            r_fill        <= n_fill;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_byte   <= n_pend_byte;
        r_byte        <= n_byte;
        r_from_mem    <= n_from_mem;
        r_copy_left   <= n_copy_left;
        r_dist        <= n_dist;
        r_rd_zero     <= n_rd_zero;
        r_out_data    <= n_out_data;
        r_out_bytes   <= n_out_bytes;
        r_item_done   <= n_item_done;
        r_stream_done <= n_stream_done;
    end

    always_ff @(posedge i_clk) begin
        if (do_put) begin
            mem[r_wp] <= put_byte;
        end
        if (mem_re) begin
            r_rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/lzd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZ77 decompressor port checker
// Watches the top-level ports for result-format and handshake rules.
// ----------------------------------------------------------------------------
module lzd_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic [7:0]                      i_data_byte,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [15:0]                     o_out_data,
    input wire logic [1:0]                      o_out_bytes,
    input wire logic                            o_item_done,
    input wire logic                            o_stream_done,
    input wire logic                            psel,
    input wire logic                            penable,
    input wire logic                            pwrite,
    input wire logic [lzd_pkg::PADDR_BITS-1:0]  paddr,
    input wire logic [31:0]                     pwdata,
    input wire logic [31:0]                     prdata,
    input wire logic                            pready
);

    a_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_bytes == 2'd1 || o_out_bytes == 2'd2))
        else $error("out_bytes outside 1..2");

    a_stream_implies_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stream_done) |-> o_item_done)
        else $error("stream_done without item_done");

    a_single_byte_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_bytes == 2'd1) |-> (o_out_data[15:8] == 8'h00))
        else $error("single byte result with nonzero high byte");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind lz77_byte_stream_decompressor_core lzd_checker u_lzd_checker (.*);
`default_nettype wire
